### design/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define DSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define DSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/dss_pkg.sv
// Types, constants and the default groove of the drum step sequencer.
package dss_pkg;

    localparam int STEP_COUNT = 16;
    localparam int NUM_VOICES = 3;
    localparam int STEP_W     = 4;
    localparam int VOICE_W    = 2;
    localparam int LEVEL_W    = 9;
    localparam int GAIN_W     = 9;
    localparam int SPS_W      = 24;
    localparam int ACC_W      = 25;
    localparam int MASK_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = 2 * LEVEL_W;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 9'd256;
    localparam logic [GAIN_W-1:0]  UNITY_GAIN = 9'd256;
    localparam logic [SPS_W-1:0]   ONE_Q8     = 24'd256;
    localparam logic [SPS_W-1:0]   SPS_RESET  = 24'd1536000;
    localparam logic [MASK_W-1:0]  MASK_RESET = 3'd7;

    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_SET     = 3'd1,
        FUNC_TOGGLE  = 3'd2,
        FUNC_READ    = 3'd3,
        FUNC_START   = 3'd4,
        FUNC_STOP    = 3'd5,
        FUNC_RESTART = 3'd6,
        FUNC_LOAD    = 3'd7
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_STEP = 3'd0,
        CFG_KICK_GAIN        = 3'd1,
        CFG_SNARE_GAIN       = 3'd2,
        CFG_HAT_GAIN         = 3'd3,
        CFG_VOICE_MASK       = 3'd4
    } t_cfg_reg;

    typedef enum logic [VOICE_W-1:0] {
        VOICE_KICK  = 2'd0,
        VOICE_SNARE = 2'd1,
        VOICE_HAT   = 2'd2
    } t_voice;

    // Item held between the state update and the result register.
    typedef struct packed {
        t_func               func;
        logic [VOICE_W-1:0]  voice;
        logic [STEP_W-1:0]   addr;
        logic [LEVEL_W-1:0]  level_in;
        logic [STEP_W-1:0]   step;
        logic                run;
        logic                fire;
    } t_stage;

    typedef struct packed {
        logic [STEP_W-1:0]                   step;
        logic                                run;
        logic [NUM_VOICES-1:0]               fire;
        logic [NUM_VOICES-1:0][LEVEL_W-1:0]  level;
        logic [LEVEL_W-1:0]                  read_level;
    } t_result;

    localparam logic [LEVEL_W-1:0] HAT_GROOVE [STEP_COUNT] = '{
        9'd256, 9'd128, 9'd179, 9'd102, 9'd230, 9'd128, 9'd154, 9'd102,
        9'd256, 9'd128, 9'd179, 9'd102, 9'd230, 9'd128, 9'd154, 9'd115
    };

    // Level of the default groove at one voice and step.
    function automatic logic [LEVEL_W-1:0] default_level(
        input logic [VOICE_W-1:0] voice,
        input logic [STEP_W-1:0]  step
    );
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        unique case (voice)
            VOICE_KICK:  lvl = (step == 4'd0 || step == 4'd8)  ? FULL_LEVEL : '0;
            VOICE_SNARE: lvl = (step == 4'd4 || step == 4'd12) ? FULL_LEVEL : '0;
            VOICE_HAT:   lvl = HAT_GROOVE[step];
            default:     lvl = '0;
        endcase
        return lvl;
    endfunction

endpackage

### design/dss_cmd_if.sv
// Command channel of the drum step sequencer.
interface dss_cmd_if import dss_pkg::*; ();
    logic                valid;
    logic                ready;
    t_func               func;
    logic [VOICE_W-1:0]  voice;
    logic [STEP_W-1:0]   step_addr;
    logic [LEVEL_W-1:0]  level_in;

    modport source (output valid, func, voice, step_addr, level_in, input ready);
    modport sink   (input valid, func, voice, step_addr, level_in, output ready);
endinterface

### design/dss_res_if.sv
// Result channel of the drum step sequencer.
interface dss_res_if import dss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STEP_W-1:0]   current_step;
    logic                playing;
    logic                kick_fire;
    logic [LEVEL_W-1:0]  kick_level;
    logic                snare_fire;
    logic [LEVEL_W-1:0]  snare_level;
    logic                hat_fire;
    logic [LEVEL_W-1:0]  hat_level;
    logic [LEVEL_W-1:0]  read_level;

    modport source (output valid, current_step, playing, kick_fire, kick_level,
                     snare_fire, snare_level, hat_fire, hat_level, read_level,
                     input ready);
    modport sink   (input valid, current_step, playing, kick_fire, kick_level,
                     snare_fire, snare_level, hat_fire, hat_level, read_level,
                     output ready);
endinterface

### design/drum_step_sequencer.sv
// Top level of the 16-step, three-voice drum step sequencer.
//
//   Channel   Direction  Handshake         Carries
//   i_cmd     in         valid/ready       func, voice, step_addr, level_in
//   o_res     out        valid/ready       step, playing, fires, levels, read_level
//   i_cfg_*   in         write enable      register index and data, no read-back
//
// One item is accepted per cycle while ready is high; the state update and pattern
// read happen at the accepting edge, then gain scaling goes into the result register
// when the middle stage moves on.
// The pattern store is a small RAM per voice with registered reads; a result waiting
// in the output register does not stop a new item from entering the middle stage.
// Reset is synchronous and active low; it needs no clearing pass, since per-entry
// valid bits make untouched entries read as the default groove.
// Ready drops only when both the middle stage and the output register are full and
// the sink does not take the waiting result.
module drum_step_sequencer import dss_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    dss_cmd_if.sink                i_cmd,
    dss_res_if.source              o_res
);

    // Configuration registers.
    logic [SPS_W-1:0]                   r_sps;
    logic [NUM_VOICES-1:0][GAIN_W-1:0]  r_gain;
    logic [MASK_W-1:0]                  r_mask;

    // Sequencer state, updated when an item is accepted.
    logic [STEP_W-1:0]  r_step, n_step;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic               r_run, n_run;
    logic               n_fire;

    // Pattern store: one RAM per voice, read at the fire step and at the addressed step.
    logic [LEVEL_W-1:0]  r_pat_mem [NUM_VOICES][STEP_COUNT];
    logic                r_pat_vld [NUM_VOICES][STEP_COUNT];
    logic [LEVEL_W-1:0]  r_rda [NUM_VOICES];
    logic [LEVEL_W-1:0]  r_rdb [NUM_VOICES];
    logic                r_defa [NUM_VOICES];
    logic                r_defb [NUM_VOICES];
    logic                r_hita [NUM_VOICES];
    logic                r_hitb [NUM_VOICES];
    logic [LEVEL_W-1:0]  r_byp;

    // Middle stage and result register.
    logic     r_s2_vld;
    t_stage   r_s2;
    logic     r_out_vld;
    t_result  r_out;
    t_result  n_out;

    logic                cmd_acc;
    logic                s2_adv;
    logic [SPS_W-1:0]    period;
    logic [ACC_W-1:0]    acc_sum;
    logic                tick_hit;

    logic [LEVEL_W-1:0]  eff_a [NUM_VOICES];
    logic [LEVEL_W-1:0]  eff_b [NUM_VOICES];
    logic [LEVEL_W-1:0]  sel_b;
    logic                voice_ok;
    logic                w_en;
    logic [LEVEL_W-1:0]  w_data;
    logic                load_commit;
    logic                hit_a [NUM_VOICES];
    logic                hit_b [NUM_VOICES];

    // ---------------------------------------------------------------------
    // Handshake. The middle stage moves on whenever the result register is
    // free or being emptied, so a held result does not block new items.
    // ---------------------------------------------------------------------
    assign s2_adv      = r_s2_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_s2_vld || s2_adv;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    // ---------------------------------------------------------------------
    // Configuration writes. Indexes past the register list are dropped.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps  <= SPS_RESET;
            r_gain <= {NUM_VOICES{UNITY_GAIN}};
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLES_PER_STEP: r_sps <= i_cfg_data;
                CFG_KICK_GAIN:        r_gain[VOICE_KICK]  <= i_cfg_data[GAIN_W-1:0];
                CFG_SNARE_GAIN:       r_gain[VOICE_SNARE] <= i_cfg_data[GAIN_W-1:0];
                CFG_HAT_GAIN:         r_gain[VOICE_HAT]   <= i_cfg_data[GAIN_W-1:0];
                CFG_VOICE_MASK:       r_mask <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Step timing. A tick while running adds one sample (256 in Q.8); reaching
    // the period subtracts it once and enters the next step. Periods shorter
    // than one sample are treated as one sample.
    // ---------------------------------------------------------------------
    assign period   = (r_sps < ONE_Q8) ? ONE_Q8 : r_sps;
    assign acc_sum  = r_acc + ACC_W'(ONE_Q8);
    assign tick_hit = acc_sum >= {1'b0, period};

    always_comb begin
        n_step = r_step;
        n_acc  = r_acc;
        n_run  = r_run;
        n_fire = 1'b0;
        unique case (i_cmd.func)
            FUNC_TICK: begin
                if (r_run) begin
                    if (tick_hit) begin
                        n_acc  = acc_sum - {1'b0, period};
                        n_step = r_step + 1'b1;
                        n_fire = 1'b1;
                    end else begin
                        n_acc = acc_sum;
                    end
                end
            end
            FUNC_START: begin
                // Start while already running is ignored.
                if (!r_run) begin
                    n_step = '0;
                    n_acc  = '0;
                    n_run  = 1'b1;
                    n_fire = 1'b1;
                end
            end
            FUNC_STOP: begin
                n_run = 1'b0;
            end
            FUNC_RESTART: begin
                n_step = '0;
                n_acc  = '0;
                n_fire = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_acc  <= '0;
            r_run  <= 1'b0;
        end else if (cmd_acc) begin
            r_step <= n_step;
            r_acc  <= n_acc;
            r_run  <= n_run;
        end
    end

    // ---------------------------------------------------------------------
    // Pattern writes happen when the item in the middle stage moves on. The
    // item accepted at that same edge reads the RAM before the write lands,
    // so matching addresses take the write data, and a default reload marks
    // both of its reads as default values.
    // ---------------------------------------------------------------------
    assign voice_ok = r_s2.voice < VOICE_W'(NUM_VOICES);

    always_comb begin
        sel_b = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (r_s2.voice == VOICE_W'(v)) begin
                sel_b = eff_b[v];
            end
        end
    end

    assign w_en   = s2_adv && voice_ok &&
                    (r_s2.func == FUNC_SET || r_s2.func == FUNC_TOGGLE);
    assign w_data = (r_s2.func == FUNC_SET) ?
                        ((r_s2.level_in > FULL_LEVEL) ? FULL_LEVEL : r_s2.level_in) :
                        ((sel_b != '0) ? '0 : FULL_LEVEL);
    assign load_commit = s2_adv && (r_s2.func == FUNC_LOAD);

    always_comb begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            hit_a[v] = w_en && (r_s2.voice == VOICE_W'(v)) && (r_s2.addr == n_step);
            hit_b[v] = w_en && (r_s2.voice == VOICE_W'(v)) && (r_s2.addr == i_cmd.step_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pat_mem[r_s2.voice][r_s2.addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (cmd_acc) begin
                r_rda[v] <= r_pat_mem[v][n_step];
                r_rdb[v] <= r_pat_mem[v][i_cmd.step_addr];
            end
        end
    end

    // Valid bits: an entry never written since reset or the last reload
    // reads as its default groove level.
    always_ff @(posedge i_clk) begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            for (int s = 0; s < STEP_COUNT; s++) begin
                if (!i_rst_n || load_commit) begin
                    r_pat_vld[v][s] <= 1'b0;
                end else if (w_en && r_s2.voice == VOICE_W'(v) && r_s2.addr == STEP_W'(s)) begin
                    r_pat_vld[v][s] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_byp <= w_data;
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_hita[v] <= hit_a[v];
                r_hitb[v] <= hit_b[v];
                r_defa[v] <= !hit_a[v] && (load_commit || !r_pat_vld[v][n_step]);
                r_defb[v] <= !hit_b[v] && (load_commit || !r_pat_vld[v][i_cmd.step_addr]);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Middle stage.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (cmd_acc) begin
            r_s2_vld <= 1'b1;
        end else if (s2_adv) begin
            r_s2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_s2.func     <= i_cmd.func;
            r_s2.voice    <= i_cmd.voice;
            r_s2.addr     <= i_cmd.step_addr;
            r_s2.level_in <= i_cmd.level_in;
            r_s2.step     <= n_step;
            r_s2.run      <= n_run;
            r_s2.fire     <= n_fire;
        end
    end

    always_comb begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            eff_a[v] = r_hita[v] ? r_byp :
                       r_defa[v] ? default_level(VOICE_W'(v), r_s2.step) : r_rda[v];
            eff_b[v] = r_hitb[v] ? r_byp :
                       r_defb[v] ? default_level(VOICE_W'(v), r_s2.addr) : r_rdb[v];
        end
    end

    // Trigger levels: stored level times clamped gain, divided by 256.
    always_comb begin
        logic [GAIN_W-1:0] g;
        logic [PROD_W-1:0] prod;
        n_out.step       = r_s2.step;
        n_out.run        = r_s2.run;
        n_out.read_level = (r_s2.func == FUNC_READ && voice_ok) ? sel_b : '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            g    = (r_gain[v] > UNITY_GAIN) ? UNITY_GAIN : r_gain[v];
            prod = PROD_W'(eff_a[v]) * PROD_W'(g);
            n_out.fire[v]  = r_s2.fire && r_mask[v] && (eff_a[v] != '0);
            n_out.level[v] = n_out.fire[v] ? prod[LEVEL_W+7:8] : '0;
        end
    end

    // ---------------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.current_step = r_out.step;
    assign o_res.playing      = r_out.run;
    assign o_res.kick_fire    = r_out.fire[VOICE_KICK];
    assign o_res.kick_level   = r_out.level[VOICE_KICK];
    assign o_res.snare_fire   = r_out.fire[VOICE_SNARE];
    assign o_res.snare_level  = r_out.level[VOICE_SNARE];
    assign o_res.hat_fire     = r_out.fire[VOICE_HAT];
    assign o_res.hat_level    = r_out.level[VOICE_HAT];
    assign o_res.read_level   = r_out.read_level;

endmodule

### design/dss_checker.sv
// Port-level checks of the drum step sequencer and their bind statement.
`include "assert_macros.svh"

module dss_checker import dss_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic [STEP_W-1:0]   i_current_step,
    input logic                i_playing,
    input logic                i_kick_fire,
    input logic [LEVEL_W-1:0]  i_kick_level,
    input logic                i_snare_fire,
    input logic [LEVEL_W-1:0]  i_snare_level,
    input logic                i_hat_fire,
    input logic [LEVEL_W-1:0]  i_hat_level,
    input logic [LEVEL_W-1:0]  i_read_level
);

    // A result held back by the sink stays valid and keeps its step, kick level and read level.
    `DSS_ASSERT(a_res_hold, i_valid && !i_ready |=> i_valid && $stable(i_current_step) && $stable(i_kick_level) && $stable(i_read_level), "result changed while stalled")

    // Reset empties the result register.
    `DSS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_valid, "result valid after reset")

    // A voice that does not fire reports level zero.
    `DSS_ASSERT(a_level_quiet, i_valid |-> (i_kick_fire || i_kick_level == '0) && (i_snare_fire || i_snare_level == '0) && (i_hat_fire || i_hat_level == '0), "level without fire")

    // While stopped, only a restart can fire, and that is always step zero.
    `DSS_ASSERT(a_stopped_fire, i_valid && !i_playing && (i_kick_fire || i_snare_fire || i_hat_fire) |-> i_current_step == '0, "stopped fire off step zero")

endmodule

bind drum_step_sequencer dss_checker u_dss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_current_step (o_res.current_step),
    .i_playing      (o_res.playing),
    .i_kick_fire    (o_res.kick_fire),
    .i_kick_level   (o_res.kick_level),
    .i_snare_fire   (o_res.snare_fire),
    .i_snare_level  (o_res.snare_level),
    .i_hat_fire     (o_res.hat_fire),
    .i_hat_level    (o_res.hat_level),
    .i_read_level   (o_res.read_level)
);
